FILE: hw/rtl/htb_pkg.sv
// ----------------------------------------------------------------------------
// htb_pkg
// Shared types and constants of the two-level decode table builder.
// ----------------------------------------------------------------------------
package htb_pkg;

	localparam int TABLE_DEPTH     = 2048;
	localparam int MAX_ENTRIES     = 512;
	localparam int MAX_CODE_LENGTH = 18;
	localparam int MAIN_SIZE       = 256;
	localparam int MAIN_BITS       = 8;

	localparam int TAW = $clog2(TABLE_DEPTH);
	localparam int EAW = $clog2(MAX_ENTRIES);
	localparam int ECW = EAW + 1;
	// Table word: kind(2) sym(9) len(5) base(TAW) mask(10)
	localparam int TWW = 2 + 9 + 5 + TAW + 10;
	localparam int EWW = 9 + 5;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ENTRY_OV = 2'd1,
		ST_TABLE_OV = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		K_EMPTY = 2'd0,
		K_SYM   = 2'd1,
		K_PTR   = 2'd2
	} kind_t;

	typedef enum logic [0:0] {
		CMD_APPEND = 1'b0,
		CMD_READ   = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [1:0]     kind;
		logic [8:0]     sym;
		logic [4:0]     len;
		logic [TAW-1:0] base;
		logic [9:0]     mask;
	} tword_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_SHORT_RD,
		S_SHORT_WR,
		S_GRP_RD,
		S_GRP_EVAL,
		S_GRP_PTR,
		S_FILL_RD,
		S_FILL_WR,
		S_READ_WAIT,
		S_DONE
	} state_t;

	// Reversed increment over the low len bits
	function automatic logic [17:0] rev_inc(input logic [17:0] c, input logic [4:0] len);
		logic [17:0] r;
		logic        stop;
		r    = c;
		stop = 1'b0;
		for (int b = 17; b >= 0; b--) begin
			if (!stop && (5'(b) < len)) begin
				r[b] = ~r[b];
				if (r[b])
					stop = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/huffman_two_level_table_build_unit.sv
// ----------------------------------------------------------------------------
// huffman_two_level_table_build_unit
// Collects canonical code entries and builds a two-level decode table.
// ----------------------------------------------------------------------------
// One item at a time. An append without the last mark, or a read, gives its
// result in the cycle after acceptance (the read through the registered table
// port), while busy is still high. An append marked last runs the build, paced
// by the table's single write port: it clears the main table, writes each
// short code's main entries and, once the short phase meets a long code,
// scans each long group for its longest length, writes its pointer (ending
// the build if the table would overflow) and fills its sub-table, then gives
// the result. busy stays high throughout; each item gives one result strobe
// on done, which the receiver must take in that cycle.
module huffman_two_level_table_build_unit
	import htb_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  logic           command,
	input  logic [8:0]     symbol,
	input  logic [4:0]     code_length,
	input  logic           last_entry,
	input  logic [10:0]    read_address,
	output logic           done,
	output logic [1:0]     status,
	output logic [1:0]     entry_kind,
	output logic [8:0]     out_symbol,
	output logic [4:0]     out_length,
	output logic [10:0]    sub_base,
	output logic [9:0]     sub_mask
);

	state_t state_q, state_d;

	logic [ECW-1:0] count_q;
	logic [ECW-1:0] idx_q;
	logic [ECW-1:0] gstart_q;
	logic [ECW-1:0] gend_q;
	logic [17:0]    code_q;
	logic [17:0]    first_q;
	logic [4:0]     maxlen_q;
	logic [TAW:0]   ins_q;
	logic [10:0]    u_q;
	logic [1:0]     stat_q;
	logic [8:0]     esym_q;
	logic [4:0]     elen_q;
	logic           rd_oob_q;

	// Entry store
	logic           e_we;
	logic [EAW-1:0] e_waddr, e_raddr;
	logic [EWW-1:0] e_wdata, e_rdata;
	logic [8:0]     rd_sym;
	logic [4:0]     rd_len;

	htb_ram #(.WIDTH(EWW), .DEPTH(MAX_ENTRIES)) u_entry (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rdata)
	);
	assign rd_sym = e_rdata[13:5];
	assign rd_len = e_rdata[4:0];

	// Decode table
	logic           t_we;
	logic [TAW-1:0] t_waddr, t_raddr;
	tword_t         t_wdata, t_rdata;

	htb_ram #(.WIDTH(TWW), .DEPTH(TABLE_DEPTH)) u_table (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.raddr(t_raddr), .rdata(t_rdata)
	);

	logic accept;
	logic len_ok;
	assign accept = start && !busy;
	assign len_ok = (code_length != 5'd0) && (code_length <= 5'(MAX_CODE_LENGTH));
	assign busy   = (state_q != S_IDLE);

	// Derived build values
	logic [4:0]  sub_bits;
	logic [10:0] n_words;
	logic [4:0]  e_sub;
	logic [10:0] e_step;
	logic [10:0] off;
	logic [TAW:0] ins_next;
	logic [17:0] code_inc;
	logic        short_last;
	logic        fill_last;
	assign sub_bits = maxlen_q - 5'(MAIN_BITS);
	assign n_words  = 11'(1) << sub_bits;
	assign e_sub    = (elen_q > 5'(MAIN_BITS)) ? elen_q - 5'(MAIN_BITS) : 5'd0;
	assign e_step   = 11'(1) << e_sub;
	assign off      = 11'(code_q >> MAIN_BITS) & (n_words - 11'd1) & (e_step - 11'd1);
	assign ins_next = ins_q + (TAW+1)'(n_words);
	assign code_inc = rev_inc(code_q, rd_len);
	assign short_last = (u_q + (11'(1) << elen_q)) >= 11'(MAIN_SIZE);
	assign fill_last  = (u_q + e_step) >= n_words;

	logic [7:0] low_mask;
	assign low_mask = 8'((9'(1) << elen_q) - 9'd1);

	// Short phase ends when a long length is met: divert to the groups
	logic short_to_long;
	assign short_to_long = (state_q == S_SHORT_RD);

	logic long_seen;
	assign long_seen = short_to_long && (rd_len > 5'(MAIN_BITS));

	// Next state and memory control
	always_comb begin
		state_d = state_q;
		e_we    = 1'b0;
		e_waddr = count_q[EAW-1:0];
		e_wdata = {symbol, code_length};
		e_raddr = idx_q[EAW-1:0];
		t_we    = 1'b0;
		t_waddr = '0;
		t_wdata = '0;
		t_raddr = read_address[TAW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (command == CMD_READ)
						state_d = S_READ_WAIT;
					else begin
						e_we = len_ok && (count_q < ECW'(MAX_ENTRIES));
						state_d = last_entry ? S_CLEAR : S_DONE;
					end
				end
			end
			S_CLEAR: begin
				t_we    = 1'b1;
				t_waddr = TAW'(u_q[7:0]);
				if (u_q == 11'(MAIN_SIZE - 1))
					state_d = (count_q == '0) ? S_DONE : S_SHORT_RD;
			end
			S_SHORT_RD:
				state_d = long_seen ? S_GRP_RD : S_SHORT_WR;
			S_SHORT_WR: begin
				t_we         = 1'b1;
				t_waddr      = TAW'(u_q[7:0] | (code_q[7:0] & low_mask));
				t_wdata.kind = K_SYM;
				t_wdata.sym  = esym_q;
				t_wdata.len  = elen_q;
				if (short_last) begin
					if (idx_q + 1'b1 >= count_q)
						state_d = S_DONE;
					else
						state_d = S_SHORT_RD;
				end
			end
			S_GRP_RD:
				state_d = S_GRP_EVAL;
			S_GRP_EVAL: begin
				if ((idx_q + 1'b1 >= count_q) || (code_inc[7:0] != first_q[7:0]))
					state_d = S_GRP_PTR;
				else
					state_d = S_GRP_EVAL;
			end
			S_GRP_PTR: begin
				if (ins_next > (TAW+1)'(TABLE_DEPTH))
					state_d = S_DONE;
				else begin
					t_we         = 1'b1;
					t_waddr      = TAW'(first_q[7:0]);
					t_wdata.kind = K_PTR;
					t_wdata.base = ins_q[TAW-1:0];
					t_wdata.mask = 10'(n_words - 11'd1);
					state_d      = S_FILL_RD;
				end
			end
			S_FILL_RD:
				state_d = S_FILL_WR;
			S_FILL_WR: begin
				t_we         = 1'b1;
				t_waddr      = TAW'(ins_q + (TAW+1)'((u_q | off) & (n_words - 11'd1)));
				t_wdata.kind = K_SYM;
				t_wdata.sym  = esym_q;
				t_wdata.len  = elen_q;
				if (fill_last) begin
					if (idx_q + 1'b1 < gend_q)
						state_d = S_FILL_RD;
					else if (gend_q >= count_q)
						state_d = S_DONE;
					else
						state_d = S_GRP_RD;
				end
			end
			S_READ_WAIT:
				state_d = S_IDLE;
			S_DONE:
				state_d = S_IDLE;
			default:
				state_d = S_IDLE;
		endcase
		// Present the next entry's address the cycle before its use
		if (state_q == S_GRP_EVAL)
			e_raddr = EAW'(idx_q + 1'b1);
		else if (state_q == S_GRP_PTR)
			e_raddr = gstart_q[EAW-1:0];
		else if ((state_q == S_SHORT_WR && short_last) || (state_q == S_FILL_WR && fill_last))
			e_raddr = EAW'(idx_q + 1'b1);
	end

	// Control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			gstart_q <= '0;
			gend_q   <= '0;
			code_q   <= '0;
			first_q  <= '0;
			maxlen_q <= 5'd9;
			ins_q    <= '0;
			u_q      <= '0;
			stat_q   <= ST_OK;
			rd_oob_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						stat_q   <= ST_OK;
						rd_oob_q <= (32'(read_address) >= TABLE_DEPTH);
						if (command == CMD_APPEND) begin
							if (len_ok) begin
								if (count_q < ECW'(MAX_ENTRIES))
									count_q <= count_q + 1'b1;
								else
									stat_q <= ST_ENTRY_OV;
							end
							u_q    <= '0;
							idx_q  <= '0;
							code_q <= '0;
							ins_q  <= (TAW+1)'(MAIN_SIZE);
						end
					end
				end
				S_CLEAR:
					u_q <= u_q + 11'd1;
				S_SHORT_RD:
					u_q <= '0;
				S_SHORT_WR: begin
					u_q <= u_q + (11'(1) << elen_q);
				end
				S_GRP_RD: begin
					first_q  <= code_q;
					gstart_q <= idx_q;
					maxlen_q <= 5'd9;
				end
				S_GRP_EVAL: begin
					if (rd_len > maxlen_q)
						maxlen_q <= rd_len;
					code_q <= code_inc;
					idx_q  <= idx_q + 1'b1;
				end
				S_GRP_PTR: begin
					if (ins_next > (TAW+1)'(TABLE_DEPTH))
						stat_q <= ST_TABLE_OV;
					gend_q <= idx_q;
					idx_q  <= gstart_q;
					code_q <= first_q;
				end
				S_FILL_RD:
					u_q <= '0;
				S_FILL_WR: begin
					u_q <= u_q + e_step;
					if (fill_last) begin
						code_q <= rev_inc(code_q, elen_q);
						idx_q  <= idx_q + 1'b1;
						if (idx_q + 1'b1 >= gend_q)
							ins_q <= ins_next;
					end
				end
				default: ;
			endcase
			// Short code finished: advance to the next entry
			if (state_q == S_SHORT_WR && short_last) begin
				code_q <= rev_inc(code_q, elen_q);
				idx_q  <= idx_q + 1'b1;
			end
			if (state_d == S_DONE && state_q != S_IDLE)
				count_q <= '0;
		end
	end

	// Entry fields latched from the entry store's registered read data
	logic rd_cycle;
	assign rd_cycle = (state_q == S_SHORT_RD) || (state_q == S_FILL_RD);
	always_ff @(posedge clk) begin
		if (rd_cycle) begin
			esym_q <= rd_sym;
			elen_q <= rd_len;
		end
	end

	// Result strobe and fields
	logic [1:0] out_kind;
	assign out_kind = rd_oob_q ? K_EMPTY : t_rdata.kind;
	always_comb begin
		done       = (state_q == S_DONE) || (state_q == S_READ_WAIT);
		status     = (state_q == S_DONE) ? stat_q : ST_OK;
		entry_kind = '0;
		out_symbol = '0;
		out_length = '0;
		sub_base   = '0;
		sub_mask   = '0;
		if (state_q == S_READ_WAIT) begin
			entry_kind = out_kind;
			if (out_kind == K_SYM) begin
				out_symbol = t_rdata.sym;
				out_length = t_rdata.len;
			end else if (out_kind == K_PTR) begin
				sub_base = 11'(t_rdata.base);
				sub_mask = t_rdata.mask;
			end
		end
	end

endmodule

FILE: hw/rtl/htb_ram.sv
// ----------------------------------------------------------------------------
// htb_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module htb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule
